// ===== hw/rtl/mctp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctp_pkg: shared types and codes for the task picker
// Request codes, slot state codes and the sequencer state type.
// ----------------------------------------------------------------------------
package mctp_pkg;

  // request codes
  localparam logic [1:0] REQ_SET_STATE = 2'd0;
  localparam logic [1:0] REQ_WRITE_CNT = 2'd1;
  localparam logic [1:0] REQ_PICK      = 2'd2;

  // slot state codes
  localparam logic [1:0] ST_ABSENT   = 2'd0;
  localparam logic [1:0] ST_STOPPED  = 2'd1;
  localparam logic [1:0] ST_RUNNABLE = 2'd2;

  localparam int unsigned SLICE_RST = 15;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_EVAL,
    S_REFILL,
    S_REFILL_END,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/mctp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mctp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/max_counter_task_picker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_counter_task_picker: counter-based next-task picker
// Table of task slots (state + time-slice counter) with a sequenced scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: set a slot's
//   state, write a slot's counter, or pick the next task. Every request gives
//   exactly one result on the output channel (out_valid / out_stall).
//   cfg_wr_en / cfg_wr_data load default_slice; write it only when idle.
// Timing:
//   State and counter writes finish in the accept cycle; the result shows the
//   next cycle. A pick runs one slot per cycle through a single compare unit
//   over the slot table; when that scan finds no task, a refill pass and a
//   rescan follow. The pace is set by the single read port of the slot
//   tables, one entry each cycle.
//   One request is in flight at a time; in_stall is high while a pick runs.
// Reset:
//   Synchronous, active low. All slots read absent with a zero counter
//   (per-entry valid flops, no clearing pass) and default_slice returns to 15.
// Output stall:
//   The result sits in the output register until taken; a new request is
//   only taken once that register is free or being emptied.
// ----------------------------------------------------------------------------
module max_counter_task_picker #(
  parameter int unsigned MAX_TASKS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [5:0] in_task_index,
  input  logic [1:0] in_task_state,
  input  logic [7:0] in_counter_value,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_chosen_task,
  output logic       out_found,
  output logic       out_refilled,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int unsigned IW = $clog2(MAX_TASKS);

  mctp_pkg::state_t state_r, state_nxt;

  logic [IW-1:0] addr_r, addr_nxt;          // slot being read
  logic          pend_r, pend_nxt;          // read data due this cycle
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;  // slot that data belongs to
  logic [7:0]    best_cnt_r, best_cnt_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic          refill_r, refill_nxt;
  logic [7:0]    slice_r;

  // per-slot "written since reset" flags; unwritten reads as zero
  logic st_vld_r  [MAX_TASKS];
  logic cnt_vld_r [MAX_TASKS];
  logic rd_st_vld_r, rd_cnt_vld_r;

  logic          out_valid_r, out_valid_nxt;
  logic [5:0]    out_chosen_r, out_chosen_nxt;
  logic          out_found_r, out_found_nxt;
  logic          out_refilled_r, out_refilled_nxt;

  // table ports
  logic          st_we;
  logic [IW-1:0] st_waddr;
  logic [1:0]    st_wdata;
  logic [1:0]    st_rdata;
  logic          cnt_we;
  logic [IW-1:0] cnt_waddr;
  logic [7:0]    cnt_wdata;
  logic [7:0]    cnt_rdata;

  logic          in_accept;
  logic          out_free;
  logic          last_slot;
  logic          in_range;
  logic [1:0]    rd_st;
  logic [7:0]    rd_cnt;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != mctp_pkg::S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign last_slot = (addr_r == IW'(MAX_TASKS - 1));
  assign in_range  = (32'(in_task_index) < MAX_TASKS);

  assign rd_st  = rd_st_vld_r  ? st_rdata  : mctp_pkg::ST_ABSENT;
  assign rd_cnt = rd_cnt_vld_r ? cnt_rdata : 8'd0;

  mctp_ram #(.WIDTH(2), .DEPTH(MAX_TASKS)) u_st_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (addr_r),
    .rd_data (st_rdata)
  );

  mctp_ram #(.WIDTH(8), .DEPTH(MAX_TASKS)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_addr (addr_r),
    .rd_data (cnt_rdata)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mctp_pkg::S_IDLE: begin
        if (in_accept && in_req_type == mctp_pkg::REQ_PICK) begin
          state_nxt = mctp_pkg::S_SCAN;
        end
      end
      mctp_pkg::S_SCAN: begin
        if (last_slot) begin
          state_nxt = mctp_pkg::S_SCAN_END;
        end
      end
      mctp_pkg::S_SCAN_END: begin
        state_nxt = mctp_pkg::S_EVAL;
      end
      mctp_pkg::S_EVAL: begin
        if (best_cnt_r != 8'd0 || refill_r) begin
          state_nxt = mctp_pkg::S_DONE;
        end else begin
          state_nxt = mctp_pkg::S_REFILL;
        end
      end
      mctp_pkg::S_REFILL: begin
        if (last_slot) begin
          state_nxt = mctp_pkg::S_REFILL_END;
        end
      end
      mctp_pkg::S_REFILL_END: begin
        state_nxt = mctp_pkg::S_SCAN;
      end
      mctp_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = mctp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mctp_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    addr_nxt         = addr_r;
    pend_nxt         = 1'b0;
    pend_idx_nxt     = addr_r;
    best_cnt_nxt     = best_cnt_r;
    best_idx_nxt     = best_idx_r;
    refill_nxt       = refill_r;
    st_we            = 1'b0;
    st_waddr         = IW'(in_task_index);
    st_wdata         = in_task_state;
    cnt_we           = 1'b0;
    cnt_waddr        = IW'(in_task_index);
    cnt_wdata        = in_counter_value;
    out_valid_nxt    = out_valid_r && out_stall;
    out_chosen_nxt   = out_chosen_r;
    out_found_nxt    = out_found_r;
    out_refilled_nxt = out_refilled_r;

    // shared compare unit: one slot per cycle while scanning
    if ((state_r == mctp_pkg::S_SCAN || state_r == mctp_pkg::S_SCAN_END) && pend_r) begin
      if (rd_st == mctp_pkg::ST_RUNNABLE && rd_cnt > best_cnt_r) begin
        best_cnt_nxt = rd_cnt;
        best_idx_nxt = pend_idx_r;
      end
    end

    // refill write lands in the cycle after the state read
    if ((state_r == mctp_pkg::S_REFILL || state_r == mctp_pkg::S_REFILL_END) && pend_r) begin
      if (rd_st != mctp_pkg::ST_ABSENT) begin
        cnt_we    = 1'b1;
        cnt_waddr = pend_idx_r;
        cnt_wdata = slice_r;
      end
    end

    case (state_r)
      mctp_pkg::S_IDLE: begin
        if (in_accept) begin
          case (in_req_type)
            mctp_pkg::REQ_SET_STATE: begin
              st_we = in_range && (in_task_state <= mctp_pkg::ST_RUNNABLE);
            end
            mctp_pkg::REQ_WRITE_CNT: begin
              cnt_we = in_range;
            end
            default: begin
            end
          endcase
          if (in_req_type == mctp_pkg::REQ_PICK) begin
            addr_nxt     = '0;
            best_cnt_nxt = 8'd0;
            best_idx_nxt = '0;
            refill_nxt   = 1'b0;
          end else begin
            out_valid_nxt    = 1'b1;
            out_chosen_nxt   = 6'd0;
            out_found_nxt    = 1'b0;
            out_refilled_nxt = 1'b0;
          end
        end
      end
      mctp_pkg::S_SCAN, mctp_pkg::S_REFILL: begin
        pend_nxt = 1'b1;
        addr_nxt = last_slot ? '0 : addr_r + 1'b1;
      end
      mctp_pkg::S_EVAL: begin
        if (best_cnt_r == 8'd0 && !refill_r) begin
          addr_nxt   = '0;
          refill_nxt = 1'b1;
        end
      end
      mctp_pkg::S_REFILL_END: begin
        addr_nxt     = '0;
        best_cnt_nxt = 8'd0;
        best_idx_nxt = '0;
      end
      mctp_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = (best_cnt_r != 8'd0);
          out_chosen_nxt   = (best_cnt_r != 8'd0) ? 6'(best_idx_r) : 6'd0;
          out_refilled_nxt = refill_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mctp_pkg::S_IDLE;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      best_cnt_r  <= 8'd0;
      best_idx_r  <= '0;
      refill_r    <= 1'b0;
      slice_r     <= 8'(mctp_pkg::SLICE_RST);
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        st_vld_r[i]  <= 1'b0;
        cnt_vld_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      pend_r      <= pend_nxt;
      best_cnt_r  <= best_cnt_nxt;
      best_idx_r  <= best_idx_nxt;
      refill_r    <= refill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        slice_r <= cfg_wr_data;
      end
      if (st_we) begin
        st_vld_r[st_waddr] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_vld_r[cnt_waddr] <= 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    pend_idx_r     <= pend_idx_nxt;
    rd_st_vld_r    <= st_vld_r[addr_r];
    rd_cnt_vld_r   <= cnt_vld_r[addr_r];
    out_chosen_r   <= out_chosen_nxt;
    out_found_r    <= out_found_nxt;
    out_refilled_r <= out_refilled_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_task = out_chosen_r;
  assign out_found       = out_found_r;
  assign out_refilled    = out_refilled_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the max-counter task picker
// Drives state, counter and pick requests into the slot table, keeps a
// shadow copy of the table to predict each result, and checks every result
// field by field. Both channels idle and stall at random. The default slice
// is swept across its extremes between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MAX_SLOTS = 64;

  // codes the package leaves unnamed
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [5:0] chosen;
    logic       found;
    logic       refilled;
  } pick_outcome_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // DUT inputs start at known values
  logic       in_valid = 1'b0;
  logic [1:0] in_req_type = mctp_pkg::REQ_SET_STATE;
  logic [5:0] in_task_index = '0;
  logic [1:0] in_task_state = mctp_pkg::ST_ABSENT;
  logic [7:0] in_counter_value = '0;
  logic       out_stall = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  logic       in_stall;
  logic       out_valid;
  logic [5:0] out_chosen_task;
  logic       out_found;
  logic       out_refilled;

  max_counter_task_picker #(
    .MAX_TASKS(MAX_SLOTS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_task_index   (in_task_index),
    .in_task_state   (in_task_state),
    .in_counter_value(in_counter_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chosen_task (out_chosen_task),
    .out_found       (out_found),
    .out_refilled    (out_refilled),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // --------------------------------------------------------------------------
  // Shadow of the slot table, mirrored at the moment each request is taken
  // --------------------------------------------------------------------------
  logic [1:0] slot_state [MAX_SLOTS] = '{default: mctp_pkg::ST_ABSENT};
  logic [7:0] slot_count [MAX_SLOTS] = '{default: 8'd0};
  logic [7:0] refill_slice = 8'(mctp_pkg::SLICE_RST);

  pick_outcome_t outcome_q[$];   // results owed by the block, oldest first
  int mismatches = 0;

  // idling controls: percentage of requests followed by a gap, and of free receiver cycles that start a stall
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;           // long receiver hold-off, counted down below
  int stall_left = 0;

  // Runnable slot with the highest non-zero count; lowest index on a tie.
  function automatic logic busiest_runnable(output logic [5:0] slot_idx);
    logic [7:0] top;
    top = '0;
    slot_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++)
      if (slot_state[i] == mctp_pkg::ST_RUNNABLE && slot_count[i] > top) begin
        top = slot_count[i];
        slot_idx = 6'(i);
      end
    return top != '0;
  endfunction

  // Applies one request to the shadow table and returns the result it owes.
  function automatic pick_outcome_t schedule_step(logic [1:0] kind, logic [5:0] slot,
                                                  logic [1:0] new_state, logic [7:0] count);
    pick_outcome_t res;
    res = '0;
    case (kind)
      mctp_pkg::REQ_SET_STATE: begin
        // state code 3 is dropped, the slot keeps what it had
        if (new_state != ST_INVALID) slot_state[slot] = new_state;
      end
      mctp_pkg::REQ_WRITE_CNT: begin
        slot_count[slot] = count;
      end
      mctp_pkg::REQ_PICK: begin
        res.found = busiest_runnable(res.chosen);
        if (!res.found) begin
          // nothing eligible: reload every present slot, then look once more
          res.refilled = 1'b1;
          for (int i = 0; i < MAX_SLOTS; i++)
            if (slot_state[i] != mctp_pkg::ST_ABSENT) slot_count[i] = refill_slice;
          res.found = busiest_runnable(res.chosen);
        end
      end
      default: ;  // unused request code: no effect, all-zero result
    endcase
    return res;
  endfunction

  // Gap length: mostly none, some short, the odd long one.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles--;
    else if (stall_left > 0) stall_left--;
    else stall_left = pick_gap(stall_pct);
    out_stall <= (hold_cycles > 0) || (stall_left > 0);
  end

  // --------------------------------------------------------------------------
  // Result checker: every taken result against the oldest owed one
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pick_outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $display("%0t ns: result with none owed, got chosen %0d found %0d refilled %0d",
                 $time, out_chosen_task, out_found, out_refilled);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        check_field("chosen_task", 8'(want.chosen), 8'(out_chosen_task));
        check_field("found", 8'(want.found), 8'(out_found));
        check_field("refilled", 8'(want.refilled), 8'(out_refilled));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offers one request, holds it until taken, then maybe idles. Valid is left
  // high on a zero gap so back-to-back requests never toggle it.
  task automatic send_request(logic [1:0] kind, logic [5:0] slot,
                              logic [1:0] new_state, logic [7:0] count);
    int gap;
    in_valid         <= 1'b1;
    in_req_type      <= kind;
    in_task_index    <= slot;
    in_task_state    <= new_state;
    in_counter_value <= count;
    do @(posedge clk); while (in_stall);
    outcome_q.push_back(schedule_step(kind, slot, new_state, count));
    gap = pick_gap(send_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // Register writes only with the block idle: every owed result back first.
  task automatic write_default_slice(logic [7:0] value);
    wait_results_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    refill_slice = value;
  endtask

  // Random traffic, weighted so the table stays populated and picks see ties,
  // zero counts and refills. Fields a request ignores still carry noise.
  task automatic random_requests(int count);
    int roll;
    int v;
    logic [1:0] kind;
    logic [5:0] slot;
    logic [1:0] st;
    logic [7:0] cnt;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      slot = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
      st   = 2'($urandom_range(3));
      cnt  = 8'($urandom_range(255));
      if (roll < 35) begin
        kind = mctp_pkg::REQ_SET_STATE;
        v = $urandom_range(9);
        st = (v < 1) ? ST_INVALID :
             (v < 3) ? mctp_pkg::ST_ABSENT :
             (v < 5) ? mctp_pkg::ST_STOPPED : mctp_pkg::ST_RUNNABLE;
      end else if (roll < 65) begin
        kind = mctp_pkg::REQ_WRITE_CNT;
        v = $urandom_range(9);
        if (v < 3) cnt = 8'd0;
        else if (v < 5) cnt = 8'd255;
        else if (v < 7) cnt = 8'($urandom_range(4, 1));
      end else if (roll < 95) begin
        kind = mctp_pkg::REQ_PICK;
      end else begin
        kind = REQ_UNUSED;
      end
      send_request(kind, slot, st, cnt);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Pick on an empty table, and the unused request code with every bit set.
  task automatic test_empty_table();
    send_request(mctp_pkg::REQ_PICK, 6'd0, mctp_pkg::ST_ABSENT, 8'd0);
    send_request(REQ_UNUSED, 6'd63, ST_INVALID, 8'd255);
  endtask

  // First and last slot, extreme counts, and a dropped state code.
  task automatic test_slot_extremes();
    send_request(mctp_pkg::REQ_SET_STATE, 6'd0, mctp_pkg::ST_RUNNABLE, 8'd0);
    send_request(mctp_pkg::REQ_SET_STATE, 6'd63, mctp_pkg::ST_RUNNABLE, 8'd0);
    send_request(mctp_pkg::REQ_WRITE_CNT, 6'd0, mctp_pkg::ST_ABSENT, 8'd0);
    send_request(mctp_pkg::REQ_WRITE_CNT, 6'd63, mctp_pkg::ST_ABSENT, 8'd255);
    send_request(mctp_pkg::REQ_PICK, 6'd0, mctp_pkg::ST_ABSENT, 8'd0);
    send_request(mctp_pkg::REQ_SET_STATE, 6'd63, ST_INVALID, 8'd0);
    send_request(mctp_pkg::REQ_PICK, 6'd0, mctp_pkg::ST_ABSENT, 8'd0);
  endtask

  // Equal counts go to the lower slot; a stopped slot is never chosen.
  task automatic test_tie_and_stopped();
    send_request(mctp_pkg::REQ_SET_STATE, 6'd5, mctp_pkg::ST_RUNNABLE, 8'd0);
    send_request(mctp_pkg::REQ_WRITE_CNT, 6'd5, mctp_pkg::ST_ABSENT, 8'd255);
    send_request(mctp_pkg::REQ_PICK, 6'd0, mctp_pkg::ST_ABSENT, 8'd0);
    send_request(mctp_pkg::REQ_SET_STATE, 6'd5, mctp_pkg::ST_STOPPED, 8'd0);
    send_request(mctp_pkg::REQ_PICK, 6'd0, mctp_pkg::ST_ABSENT, 8'd0);
  endtask

  // All counts run out: refill of present slots, stopped ones included.
  task automatic test_refill();
    send_request(mctp_pkg::REQ_WRITE_CNT, 6'd63, mctp_pkg::ST_ABSENT, 8'd0);
    send_request(mctp_pkg::REQ_WRITE_CNT, 6'd5, mctp_pkg::ST_ABSENT, 8'd0);
    send_request(mctp_pkg::REQ_PICK, 6'd0, mctp_pkg::ST_ABSENT, 8'd0);
  endtask

  // Zero slice leaves nothing to pick even after the refill; full slice does.
  task automatic test_default_slice();
    write_default_slice(8'd0);
    send_request(mctp_pkg::REQ_WRITE_CNT, 6'd0, mctp_pkg::ST_ABSENT, 8'd0);
    send_request(mctp_pkg::REQ_WRITE_CNT, 6'd63, mctp_pkg::ST_ABSENT, 8'd0);
    send_request(mctp_pkg::REQ_PICK, 6'd0, mctp_pkg::ST_ABSENT, 8'd0);
    write_default_slice(8'd255);
    send_request(mctp_pkg::REQ_PICK, 6'd0, mctp_pkg::ST_ABSENT, 8'd0);
  endtask

  // Random phases across the slice range; one phase runs with no idling.
  task automatic test_random_phases();
    logic [7:0] slices [5];
    slices = '{8'd1, 8'd255, 8'($urandom_range(254, 2)), 8'd0,
               8'(mctp_pkg::SLICE_RST)};
    foreach (slices[p]) begin
      write_default_slice(slices[p]);
      send_gap_pct = (p == 2) ? 0 : 30;
      stall_pct    = (p == 2) ? 0 : 30;
      random_requests(130);
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // output register fills and the block pushes back on its input.
  task automatic test_output_hold();
    send_gap_pct = 0;
    hold_cycles = 300;
    random_requests(30);
  endtask

  // Sender stops mid-stream until every owed result is back, then resumes.
  task automatic test_sender_pause();
    send_gap_pct = 20;
    stall_pct = 20;
    random_requests(20);
    wait_results_drained();
    random_requests(20);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct = 20;
    test_empty_table();
    test_slot_extremes();
    test_tie_and_stopped();
    test_refill();
    test_default_slice();
    test_random_phases();
    test_output_hold();
    test_sender_pause();
    wait_results_drained();
    // wait on past the slowest pick to catch any stray result
    repeat (250) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mctp_pkg.sv
hw/rtl/mctp_ram.sv
hw/rtl/max_counter_task_picker.sv
tb/tb_top.sv
